[sv/chash_pkg.sv]
`timescale 1ns / 1ps
package chash_pkg;

    localparam int CFG_WIDTH    = 11;
    localparam int STATUS_WIDTH = 3;
    localparam int RDATA_WIDTH  = 32;

    localparam logic OP_SET = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic [STATUS_WIDTH-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL      = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_GCLR,
        S_RB_RD,
        S_RB_KEY,
        S_DIV,
        S_HRD,
        S_HCHK,
        S_RB_LNK,
        S_NRD,
        S_NCMP,
        S_INS_LNK,
        S_DONE
    } t_state;

endpackage

[sv/chained_hash_table_top.sv]
`timescale 1ns / 1ps
// A get or a set without growth runs the serial key mod bucket count divider (one bit per cycle),
// reads the bucket head, then visits chain nodes in the one-port memories; an insert at a
// non-empty chain adds a tail link write. A set that grows first clears the new bucket heads
// and rehashes every node through the divider.
// One request at a time, taken when the previous result reaches the output; a result waits in the output.
// Reset (synchronous) and a configuration write run a clearing pass over all MAX_BUCKETS heads.
module chained_hash_table_top #(
    parameter int MAX_BUCKETS   = 1024,
    parameter int NODE_CAPACITY = 768,
    parameter int KEY_WIDTH     = 32,
    parameter int VALUE_WIDTH   = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_operation,
    input  logic [KEY_WIDTH-1:0]               i_key,
    input  logic [VALUE_WIDTH-1:0]             i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [chash_pkg::RDATA_WIDTH-1:0]  o_read_value,
    output logic [chash_pkg::STATUS_WIDTH-1:0] o_status,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [chash_pkg::CFG_WIDTH-1:0]    i_cfg_data
);

    localparam int HW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int BW  = $clog2(MAX_BUCKETS + 1);
    localparam int NW  = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1;
    localparam int CW  = $clog2(NODE_CAPACITY + 1);
    localparam int LW  = ((CW > BW) ? CW : BW) + 3;
    localparam int DCW = $clog2(KEY_WIDTH);
    localparam int INIT_BUCKETS = (MAX_BUCKETS < 4) ? MAX_BUCKETS : 4;

    typedef struct packed {
        logic          v;
        logic [NW-1:0] hd;
        logic [NW-1:0] tl;
    } t_head;

    typedef struct packed {
        logic          v;
        logic [NW-1:0] nx;
    } t_link;

    t_head                head_mem [MAX_BUCKETS];
    logic [KEY_WIDTH-1:0]   key_mem  [NODE_CAPACITY];
    logic [VALUE_WIDTH-1:0] val_mem  [NODE_CAPACITY];
    t_link                link_mem [NODE_CAPACITY];

    chash_pkg::t_state r_state, n_state;
    logic [BW-1:0]   r_init, n_init, r_bt, n_bt;
    logic [CW-1:0]   r_cnt, n_cnt, r_i, n_i;
    logic            r_op, n_op, r_rb, n_rb;
    logic [KEY_WIDTH-1:0]   r_key, n_key, r_dkey, n_dkey;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [NW-1:0]   r_idx, n_idx;
    logic [BW-1:0]   r_rem, n_rem;
    logic [DCW-1:0]  r_dcnt, n_dcnt;
    logic [HW-1:0]   r_clr, n_clr;
    t_head           r_head, n_head;
    logic            r_ov, n_ov;
    logic [chash_pkg::RDATA_WIDTH-1:0]  r_rv, n_rv, r_prv, n_prv;
    logic [chash_pkg::STATUS_WIDTH-1:0] r_st, n_st, r_pst, n_pst;

    t_head                r_hd_q;
    logic [KEY_WIDTH-1:0]   r_key_q;
    logic [VALUE_WIDTH-1:0] r_val_q;
    t_link                r_lnk_q;

    logic          hd_we, kv_we, v_we, l_we;
    logic [HW-1:0] hd_waddr, hd_raddr;
    t_head         hd_wdata;
    logic [NW-1:0] n_waddr, l_waddr, v_waddr, nd_raddr;
    t_link         l_wdata;
    logic [VALUE_WIDTH-1:0] v_wdata;

    logic [BW:0]   div_t;
    logic [LW-1:0] load_l, load_r, bt2;
    logic [chash_pkg::CFG_WIDTH-1:0] cfg_v;
    t_head         cur_head;
    logic [NW-1:0] new_n;

    assign o_stall      = (r_state != chash_pkg::S_IDLE) || i_cfg_valid;
    assign o_cfg_ready  = (r_state == chash_pkg::S_IDLE);
    assign o_valid      = r_ov;
    assign o_read_value = r_rv;
    assign o_status     = r_st;

    assign div_t  = {r_rem, r_dkey[KEY_WIDTH-1]};
    assign load_l = LW'(r_cnt) << 2;
    assign load_r = LW'(r_bt) + (LW'(r_bt) << 1);
    assign bt2    = LW'(r_bt) << 1;
    assign cfg_v  = i_cfg_data;
    assign cur_head = (r_state == chash_pkg::S_HCHK) ? r_hd_q : r_head;
    assign new_n  = r_cnt[NW-1:0];

    always_comb begin
        n_state = r_state;
        n_init = r_init; n_bt = r_bt; n_cnt = r_cnt; n_i = r_i;
        n_op = r_op; n_rb = r_rb; n_key = r_key; n_dkey = r_dkey; n_val = r_val;
        n_idx = r_idx; n_rem = r_rem; n_dcnt = r_dcnt; n_clr = r_clr; n_head = r_head;
        n_ov = r_ov && i_stall; n_rv = r_rv; n_st = r_st; n_prv = r_prv; n_pst = r_pst;
        hd_we = 1'b0; kv_we = 1'b0; v_we = 1'b0; l_we = 1'b0;
        hd_waddr = r_clr; hd_wdata = '0; hd_raddr = r_rem[HW-1:0];
        n_waddr = new_n; l_waddr = new_n; l_wdata = '0;
        v_waddr = new_n; v_wdata = r_val;
        nd_raddr = r_idx;
        unique case (r_state)
            chash_pkg::S_CLEAR: begin
                hd_we = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == HW'(MAX_BUCKETS - 1)) begin
                    n_state = chash_pkg::S_IDLE;
                end
            end
            chash_pkg::S_IDLE: begin
                if (i_cfg_valid) begin
                    if (cfg_v == '0) begin
                        n_init = BW'(1);
                    end else if (32'(cfg_v) > 32'(MAX_BUCKETS)) begin
                        n_init = BW'(MAX_BUCKETS);
                    end else begin
                        n_init = BW'(cfg_v);
                    end
                    n_bt = n_init;
                    n_cnt = '0;
                    n_clr = '0;
                    n_state = chash_pkg::S_CLEAR;
                end else if (i_valid) begin
                    n_op = i_operation;
                    n_key = i_key;
                    n_val = i_value;
                    n_prv = '0;
                    n_rb = 1'b0; n_dkey = i_key; n_rem = '0; n_dcnt = '0;
                    n_state = chash_pkg::S_DIV;
                    if (i_operation == chash_pkg::OP_SET && load_l >= load_r) begin
                        if (bt2 > LW'(MAX_BUCKETS)) begin
                            n_pst = chash_pkg::ST_FULL;
                            n_state = chash_pkg::S_DONE;
                        end else begin
                            n_bt = BW'(bt2);
                            n_clr = '0;
                            n_i = '0;
                            n_state = chash_pkg::S_GCLR;
                        end
                    end
                end
            end
            chash_pkg::S_GCLR: begin
                hd_we = 1'b1;
                n_clr = r_clr + 1'b1;
                if (BW'(r_clr) == r_bt - 1'b1) begin
                    if (r_cnt == '0) begin
                        n_rb = 1'b0; n_dkey = r_key; n_rem = '0; n_dcnt = '0;
                        n_state = chash_pkg::S_DIV;
                    end else begin
                        n_state = chash_pkg::S_RB_RD;
                    end
                end
            end
            chash_pkg::S_RB_RD: begin
                nd_raddr = r_i[NW-1:0];
                l_we = 1'b1;
                l_waddr = r_i[NW-1:0];
                n_state = chash_pkg::S_RB_KEY;
            end
            chash_pkg::S_RB_KEY: begin
                n_rb = 1'b1; n_dkey = r_key_q; n_rem = '0; n_dcnt = '0;
                n_state = chash_pkg::S_DIV;
            end
            chash_pkg::S_DIV: begin
                if (div_t >= {1'b0, r_bt}) begin
                    n_rem = BW'(div_t - {1'b0, r_bt});
                end else begin
                    n_rem = BW'(div_t);
                end
                n_dkey = r_dkey << 1;
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == DCW'(KEY_WIDTH - 1)) begin
                    n_state = chash_pkg::S_HRD;
                end
            end
            chash_pkg::S_HRD: begin
                n_state = chash_pkg::S_HCHK;
            end
            chash_pkg::S_HCHK: begin
                n_head = r_hd_q;
                if (r_rb) begin
                    hd_we = 1'b1;
                    hd_waddr = r_rem[HW-1:0];
                    hd_wdata = r_hd_q.v ? {1'b1, r_hd_q.hd, r_i[NW-1:0]}
                                        : {1'b1, r_i[NW-1:0], r_i[NW-1:0]};
                    if (r_hd_q.v) begin
                        n_state = chash_pkg::S_RB_LNK;
                    end else begin
                        n_i = r_i + 1'b1;
                        if (r_i + 1'b1 == r_cnt) begin
                            n_rb = 1'b0; n_dkey = r_key; n_rem = '0; n_dcnt = '0;
                            n_state = chash_pkg::S_DIV;
                        end else begin
                            n_state = chash_pkg::S_RB_RD;
                        end
                    end
                end else if (r_hd_q.v) begin
                    n_idx = r_hd_q.hd;
                    n_state = chash_pkg::S_NRD;
                end else begin
                    n_state = chash_pkg::S_DONE;
                end
            end
            chash_pkg::S_RB_LNK: begin
                l_we = 1'b1;
                l_waddr = r_head.tl;
                l_wdata = '{1'b1, r_i[NW-1:0]};
                n_i = r_i + 1'b1;
                if (r_i + 1'b1 == r_cnt) begin
                    n_rb = 1'b0; n_dkey = r_key; n_rem = '0; n_dcnt = '0;
                    n_state = chash_pkg::S_DIV;
                end else begin
                    n_state = chash_pkg::S_RB_RD;
                end
            end
            chash_pkg::S_NRD: begin
                n_state = chash_pkg::S_NCMP;
            end
            chash_pkg::S_NCMP: begin
                if (r_key_q == r_key) begin
                    if (r_op == chash_pkg::OP_GET) begin
                        n_prv = chash_pkg::RDATA_WIDTH'(r_val_q);
                        n_pst = chash_pkg::ST_FOUND;
                    end else begin
                        v_we = 1'b1;
                        v_waddr = r_idx;
                        n_pst = chash_pkg::ST_UPDATED;
                    end
                    n_state = chash_pkg::S_DONE;
                end else if (r_lnk_q.v) begin
                    n_idx = r_lnk_q.nx;
                    n_state = chash_pkg::S_NRD;
                end else begin
                    n_state = chash_pkg::S_DONE;
                end
            end
            chash_pkg::S_INS_LNK: begin
                l_we = 1'b1;
                l_waddr = r_head.tl;
                l_wdata = '{1'b1, r_idx};
                n_state = chash_pkg::S_DONE;
            end
            chash_pkg::S_DONE: begin
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1;
                    n_rv = r_prv;
                    n_st = r_pst;
                    n_state = chash_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = chash_pkg::S_IDLE;
            end
        endcase
        // miss handling: not found on get, insert or refuse on set
        if (((r_state == chash_pkg::S_HCHK) && !r_rb && !r_hd_q.v) ||
            ((r_state == chash_pkg::S_NCMP) && (r_key_q != r_key) && !r_lnk_q.v)) begin
            if (r_op == chash_pkg::OP_GET) begin
                n_pst = chash_pkg::ST_NOT_FOUND;
            end else if (r_cnt >= CW'(NODE_CAPACITY)) begin
                n_pst = chash_pkg::ST_FULL;
            end else begin
                kv_we = 1'b1;
                v_we = 1'b1;
                l_we = 1'b1;
                hd_we = 1'b1;
                hd_waddr = r_rem[HW-1:0];
                hd_wdata = cur_head.v ? {1'b1, cur_head.hd, new_n} : {1'b1, new_n, new_n};
                n_cnt = r_cnt + 1'b1;
                n_idx = new_n;
                n_pst = chash_pkg::ST_INSERTED;
                if (cur_head.v) begin
                    n_state = chash_pkg::S_INS_LNK;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chash_pkg::S_CLEAR;
            r_init  <= BW'(INIT_BUCKETS);
            r_bt    <= BW'(INIT_BUCKETS);
            r_cnt   <= '0;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_bt    <= n_bt;
            r_cnt   <= n_cnt;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_op <= n_op; r_rb <= n_rb; r_key <= n_key; r_dkey <= n_dkey;
        r_val <= n_val; r_idx <= n_idx; r_rem <= n_rem; r_dcnt <= n_dcnt;
        r_head <= n_head; r_rv <= n_rv; r_st <= n_st; r_prv <= n_prv; r_pst <= n_pst;
    end

    always_ff @(posedge i_clk) begin
        if (hd_we) begin
            head_mem[hd_waddr] <= hd_wdata;
        end
        r_hd_q <= head_mem[hd_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (kv_we) begin
            key_mem[n_waddr] <= r_key;
        end
        r_key_q <= key_mem[nd_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            val_mem[v_waddr] <= v_wdata;
        end
        r_val_q <= val_mem[nd_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            link_mem[l_waddr] <= l_wdata;
        end
        r_lnk_q <= link_mem[nd_raddr];
    end

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(NODE_CAPACITY))
        else $error("node count above capacity");

    a_bt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bt != '0) && (r_bt <= BW'(MAX_BUCKETS)) && (r_init <= r_bt))
        else $error("bucket count out of range");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != chash_pkg::S_IDLE))
        else $error("request accepted without work");

    a_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= chash_pkg::ST_FULL) &&
                    ((o_status == chash_pkg::ST_FOUND) || (o_read_value == '0)))
        else $error("bad result");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;

    localparam int NBUCKETS  = 1024;
    localparam int NNODES    = 768;
    localparam int WDOG_MAX  = 200000;

    typedef struct {
        logic [chash_pkg::RDATA_WIDTH-1:0]  rv;
        logic [chash_pkg::STATUS_WIDTH-1:0] st;
    } t_result;

    class chain_table_model;
        logic [9:0]  head[NBUCKETS];
        bit          head_ok[NBUCKETS];
        int          tail[NBUCKETS];
        logic [31:0] nkey[NNODES];
        logic [31:0] nval[NNODES];
        logic [9:0]  nlink[NNODES];
        bit          link_ok[NNODES];
        int          count;
        int          total;
        int          init_buckets;
        t_result     pending_results[$];
        int          errors;

        function new();
            init_buckets = 4;
            errors = 0;
            clear();
        endfunction

        function void clear();
            foreach (head_ok[i]) head_ok[i] = 0;
            foreach (link_ok[i]) link_ok[i] = 0;
            count = 0;
            total = init_buckets;
        endfunction

        function void set_buckets(logic [chash_pkg::CFG_WIDTH-1:0] v);
            int b;
            b = v;
            if (b == 0) b = 1;
            if (b > NBUCKETS) b = NBUCKETS;
            init_buckets = b;
            clear();
        endfunction

        function int bucket(logic [31:0] k);
            return int'(k % 32'(total));
        endfunction

        function void link_node(int n, int b);
            if (!head_ok[b]) begin
                head_ok[b] = 1;
                head[b] = n;
            end else begin
                nlink[tail[b]] = n;
                link_ok[tail[b]] = 1;
            end
            tail[b] = n;
        endfunction

        function bit lookup(logic [31:0] k, output int at);
            int b;
            int idx;
            b = bucket(k);
            at = 0;
            if (!head_ok[b]) return 0;
            idx = head[b];
            forever begin
                if (nkey[idx] == k) begin
                    at = idx;
                    return 1;
                end
                if (!link_ok[idx]) return 0;
                idx = nlink[idx];
            end
        endfunction

        function logic [chash_pkg::STATUS_WIDTH-1:0] apply_set(logic [31:0] k,
                                                               logic [31:0] v);
            int at;
            int b;
            if (4 * count >= 3 * total) begin
                if (2 * total > NBUCKETS) return chash_pkg::ST_FULL;
                total = 2 * total;
                foreach (head_ok[i]) head_ok[i] = 0;
                for (int i = 0; i < count; i++) begin
                    link_ok[i] = 0;
                    link_node(i, bucket(nkey[i]));
                end
            end
            if (lookup(k, at)) begin
                nval[at] = v;
                return chash_pkg::ST_UPDATED;
            end
            if (count >= NNODES) return chash_pkg::ST_FULL;
            nkey[count] = k;
            nval[count] = v;
            link_ok[count] = 0;
            b = bucket(k);
            if (head_ok[b]) begin
                // append at the true chain tail
                int t;
                t = head[b];
                while (link_ok[t]) t = nlink[t];
                tail[b] = t;
            end
            link_node(count, b);
            count++;
            return chash_pkg::ST_INSERTED;
        endfunction

        function void note_request(logic op, logic [31:0] k, logic [31:0] v);
            t_result r;
            int at;
            r.rv = '0;
            if (op == chash_pkg::OP_SET) begin
                r.st = apply_set(k, v);
            end else if (lookup(k, at)) begin
                r.rv = nval[at];
                r.st = chash_pkg::ST_FOUND;
            end else begin
                r.st = chash_pkg::ST_NOT_FOUND;
            end
            pending_results.insert(pending_results.size(), r);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_response(logic [31:0] rv, logic [2:0] st);
            t_result r;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected response rv=%h st=%0d", rv, st));
                return;
            end
            r = pending_results.pop_front();
            if (st !== r.st)
                report($sformatf("status got %0d want %0d", st, r.st));
            if (rv !== r.rv)
                report($sformatf("read_value got %h want %h", rv, r.rv));
        endtask
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_stall;
    logic                               i_operation;
    logic [31:0]                        i_key;
    logic [31:0]                        i_value;
    logic                               o_valid;
    logic                               i_stall;
    logic [chash_pkg::RDATA_WIDTH-1:0]  o_read_value;
    logic [chash_pkg::STATUS_WIDTH-1:0] o_status;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [chash_pkg::CFG_WIDTH-1:0]    i_cfg_data;

    chained_hash_table_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    chain_table_model table_model = new();
    logic [31:0]      used_keys[$];
    int               idle_cycles;
    bit               no_gaps;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receive side: random stall per response
    initial begin
        int n;
        i_stall <= 1'b0;
        forever begin
            n = $urandom_range(3) == 0 ? 0 : $urandom_range(12);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            table_model.check_response(o_read_value, o_status);
        end
    end

    task automatic send_request(logic op, logic [31:0] k, logic [31:0] v);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_key       <= k;
        i_value     <= v;
        do @(posedge i_clk); while (o_stall);
        table_model.note_request(op, k, v);
        if (op == chash_pkg::OP_SET) used_keys.insert(used_keys.size(), k);
    endtask

    task automatic write_buckets(logic [chash_pkg::CFG_WIDTH-1:0] v);
        i_valid <= 1'b0;
        while (table_model.pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        table_model.set_buckets(v);
        used_keys.delete();
    endtask

    function automatic logic [31:0] pick_key(int span, bit fresh);
        if (!fresh && used_keys.size() != 0 && $urandom_range(1))
            return used_keys[$urandom_range(used_keys.size() - 1)];
        return span == 0 ? $urandom() : $urandom_range(span);
    endfunction

    task automatic random_requests(int count, int span, int get_pct, bit fresh);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) no_gaps = ($urandom_range(3) == 0);
            send_request($urandom_range(99) < get_pct ? chash_pkg::OP_GET : chash_pkg::OP_SET,
                         pick_key(span, fresh), $urandom());
        end
    endtask

    initial begin
        idle_cycles = 0;
        no_gaps     = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_operation <= chash_pkg::OP_SET;
        i_key       <= '0;
        i_value     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(chash_pkg::OP_GET, 32'd5, 32'hFFFF_FFFF);
        send_request(chash_pkg::OP_SET, 32'd0, 32'd0);
        send_request(chash_pkg::OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(chash_pkg::OP_GET, 32'hFFFF_FFFF, 32'd0);
        send_request(chash_pkg::OP_SET, 32'd0, 32'h1234_5678);
        send_request(chash_pkg::OP_GET, 32'd0, 32'd0);
        send_request(chash_pkg::OP_SET, 32'd4, 32'hA5A5_A5A5);
        send_request(chash_pkg::OP_SET, 32'd8, 32'h5A5A_5A5A);
        send_request(chash_pkg::OP_SET, 32'd12, 32'h8000_0000);
        send_request(chash_pkg::OP_SET, 32'd16, 32'h0000_0001);
        send_request(chash_pkg::OP_GET, 32'd8, 32'd0);
        send_request(chash_pkg::OP_GET, 32'd20, 32'd0);
        send_request(chash_pkg::OP_SET, 32'd4, 32'd7);
        send_request(chash_pkg::OP_GET, 32'd4, 32'd0);
        send_request(chash_pkg::OP_GET, 32'h8000_0000, 32'd0);
        send_request(chash_pkg::OP_SET, 32'h8000_0000, 32'hDEAD_BEEF);

        write_buckets(11'd0);
        random_requests(200, 255, 40, 1'b0);

        // fill the node store to refusal
        write_buckets(11'd2047);
        random_requests(780, 0, 0, 1'b1);
        random_requests(30, 0, 30, 1'b0);

        write_buckets(11'd1024);
        random_requests(60, 0, 40, 1'b0);

        write_buckets(11'd3);
        random_requests(120, 1023, 40, 1'b0);

        i_valid <= 1'b0;
        while (table_model.pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (table_model.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[chained_hash_table_top.f]
sv/chash_pkg.sv
sv/chained_hash_table_top.sv
test/tb.sv
